/* rtl/qsld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsld_pkg
// Shared codes, types and byte classifiers for the quoted string decoder.
// ----------------------------------------------------------------------------
package qsld_pkg;

    localparam int MAX_LEN_DEF = 4096;

    localparam int BYTE_W = 8;
    localparam int STAT_W = 4;
    localparam int LEN_W  = 13;
    localparam int MODE_W = 3;

    // parse modes
    localparam logic [MODE_W-1:0] M_IDLE        = 3'd0;
    localparam logic [MODE_W-1:0] M_RAW_OPEN    = 3'd1;
    localparam logic [MODE_W-1:0] M_BASIC_OPEN  = 3'd2;
    localparam logic [MODE_W-1:0] M_RAW_BODY    = 3'd3;
    localparam logic [MODE_W-1:0] M_BASIC_BODY  = 3'd4;
    localparam logic [MODE_W-1:0] M_BASIC_ESC   = 3'd5;
    localparam logic [MODE_W-1:0] M_RAW_EMPTY   = 3'd6;
    localparam logic [MODE_W-1:0] M_BASIC_EMPTY = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STAT_W-1:0] ST_BUSY     = 4'd1;
    localparam logic [STAT_W-1:0] ST_DONE     = 4'd2;
    localparam logic [STAT_W-1:0] ST_NOTSTR   = 4'd3;
    localparam logic [STAT_W-1:0] ST_CTRL     = 4'd4;
    localparam logic [STAT_W-1:0] ST_NONASCII = 4'd5;
    localparam logic [STAT_W-1:0] ST_UNTERM   = 4'd6;
    localparam logic [STAT_W-1:0] ST_MULTI    = 4'd7;
    localparam logic [STAT_W-1:0] ST_BADESC   = 4'd8;

    // characters
    localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LC_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LC_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LC_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LC_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LC_E  = 8'h65;

    typedef logic [MODE_W-1:0] t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              ch_vld;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  len;
    } t_res;

    // tab or printable ascii
    function automatic logic plain_byte(input logic [BYTE_W-1:0] c);
        plain_byte = (c == CH_TAB) || ((c >= CH_SPACE) && (c < CH_DEL));
    endfunction

    // {hit, decoded byte}
    function automatic logic [BYTE_W:0] esc_decode(input logic [BYTE_W-1:0] c);
        logic [BYTE_W:0] r;
        r = '0;
        unique case (c)
            CH_LC_B:  r = {1'b1, CH_BS};
            CH_LC_T:  r = {1'b1, CH_TAB};
            CH_LC_N:  r = {1'b1, CH_LF};
            CH_LC_F:  r = {1'b1, CH_FF};
            CH_LC_R:  r = {1'b1, CH_CR};
            CH_LC_E:  r = {1'b1, CH_ESC};
            CH_QUOTE: r = {1'b1, CH_QUOTE};
            CH_BSL:   r = {1'b1, CH_BSL};
            default:  r = '0;
        endcase
        esc_decode = r;
    endfunction

endpackage

/* rtl/qsld_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsld_step
// Next parse mode, byte count and result for one input byte.
// ----------------------------------------------------------------------------
module qsld_step
    import qsld_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  t_mode                             i_mode,
    input  logic [$clog2(MAX_LEN+1)-1:0]      i_count,
    input  logic [BYTE_W-1:0]                 i_byte,
    input  logic                              i_first,
    input  logic                              i_last,
    output t_mode                             o_mode,
    output logic [$clog2(MAX_LEN+1)-1:0]      o_count,
    output t_res                              o_res
);

    localparam int CNT_W = $clog2(MAX_LEN+1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_EMPTY = LEN_W'(2);

    logic [CNT_W-1:0]       cnt_inc;
    logic [CNT_W+LEN_W-1:0] len_ext;
    logic                   raw;
    logic                   is_open;
    logic                   accepted;
    logic [BYTE_W-1:0]      q;
    t_mode                  body_mode;
    logic [BYTE_W:0]        esc;

    assign cnt_inc = i_count + CNT_W'(1);
    assign len_ext = {{LEN_W{1'b0}}, cnt_inc};
    assign raw     = (i_mode == M_RAW_OPEN) || (i_mode == M_RAW_BODY)
                  || (i_mode == M_RAW_EMPTY);
    assign is_open = (i_mode == M_RAW_OPEN) || (i_mode == M_BASIC_OPEN);
    assign q       = raw ? CH_APOS : CH_QUOTE;
    assign esc     = esc_decode(i_byte);
    assign body_mode = is_open ? (raw ? M_RAW_BODY : M_BASIC_BODY) : i_mode;

    always_comb begin
        o_mode   = i_mode;
        o_count  = i_count;
        o_res    = '0;
        accepted = 1'b0;
        if (i_first) begin
            o_count = CNT_W'(1);
            if (((i_byte == CH_APOS) || (i_byte == CH_QUOTE)) && !i_last) begin
                o_mode       = (i_byte == CH_APOS) ? M_RAW_OPEN : M_BASIC_OPEN;
                o_res.status = ST_BUSY;
            end else begin
                o_mode       = M_IDLE;
                o_res.status = ST_NOTSTR;
            end
        end else if (i_mode == M_IDLE) begin
            o_res.status = ST_IDLE;
        end else if ((i_mode == M_RAW_EMPTY) || (i_mode == M_BASIC_EMPTY)) begin
            // third byte only tells an empty string from a multi-line opener
            if (i_byte == q) begin
                o_res.status = ST_MULTI;
            end else begin
                o_res.status = ST_DONE;
                o_res.len    = LEN_EMPTY;
            end
            o_mode = M_IDLE;
        end else begin
            o_count = cnt_inc;
            o_mode  = body_mode;
            priority if (is_open && (i_byte == q)) begin
                if (i_last) begin
                    o_res.status = ST_DONE;
                    o_res.len    = LEN_EMPTY;
                    o_mode       = M_IDLE;
                end else begin
                    o_res.status = ST_BUSY;
                    o_mode       = raw ? M_RAW_EMPTY : M_BASIC_EMPTY;
                end
            end else if (body_mode == M_BASIC_ESC) begin
                if (esc[BYTE_W]) begin
                    o_res.ch     = esc[BYTE_W-1:0];
                    o_res.ch_vld = 1'b1;
                    accepted     = 1'b1;
                    o_mode       = M_BASIC_BODY;
                end else begin
                    o_res.status = ST_BADESC;
                    o_mode       = M_IDLE;
                end
            end else if (i_byte == q) begin
                o_res.status = ST_DONE;
                o_res.len    = len_ext[LEN_W-1:0];
                o_mode       = M_IDLE;
            end else if (!raw && (i_byte == CH_BSL)) begin
                accepted = 1'b1;
                o_mode   = M_BASIC_ESC;
            end else if (plain_byte(i_byte)) begin
                o_res.ch     = i_byte;
                o_res.ch_vld = 1'b1;
                accepted     = 1'b1;
            end else begin
                o_res.status = i_byte[BYTE_W-1] ? ST_NONASCII : ST_CTRL;
                o_mode       = M_IDLE;
            end
            if (accepted) begin
                if (i_last || (cnt_inc >= MAX_CNT)) begin
                    o_res.status = ST_UNTERM;
                    o_res.ch     = '0;
                    o_res.ch_vld = 1'b0;
                    o_mode       = M_IDLE;
                end else begin
                    o_res.status = ST_BUSY;
                end
            end
        end
    end

endmodule

/* rtl/quoted_string_literal_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_literal_decoder
// Decodes a single-line raw or basic quoted string, one byte per beat.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one output beat, in order. The block takes
// one byte per clock cycle when the output side keeps up; the result of a
// byte goes from the input register to the result register before it shows
// on the output. The rate is set by the parse mode and byte count registers,
// which are updated once per byte by a single pass of decode logic. The input
// register and the result register each hold one beat, so a new byte is
// still taken while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module quoted_string_literal_decoder
    import qsld_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_first,
    input  logic              i_last,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_char,
    output logic              o_char_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [LEN_W-1:0]  o_end_length
);

    localparam int CNT_W = $clog2(MAX_LEN+1);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_in_last;

    // parse state
    t_mode             r_mode;
    t_mode             n_mode;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // result register
    logic              r_out_valid;
    t_res              r_out;
    t_res              n_out;

    logic              out_free;
    logic              advance;
    logic              in_take;

    // result register can take a beat when empty or being drained
    assign out_free = !r_out_valid || !i_stall;
    // the held input beat moves on and updates the parse state
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    qsld_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_byte  (r_in_byte),
        .i_first (r_in_first),
        .i_last  (r_in_last),
        .o_mode  (n_mode),
        .o_count (n_count),
        .o_res   (n_out)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= M_IDLE;
            r_count     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_count     <= n_count;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_in_byte;
            r_in_first <= i_first;
            r_in_last  <= i_last;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out.ch;
    assign o_char_valid = r_out.ch_vld;
    assign o_status     = r_out.status;
    assign o_end_length = r_out.len;

endmodule

/* rtl/qsld_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsld_chk
// Port-level checks for the quoted string decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qsld_chk
    import qsld_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [BYTE_W-1:0] o_out_char,
    input logic              o_char_valid,
    input logic [STAT_W-1:0] o_status,
    input logic [LEN_W-1:0]  o_end_length
);

    // a decoded byte only comes with busy
    a_char_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_valid) |-> (o_status == ST_BUSY))
        else $error("decoded byte without busy status");

    // length only reported on done
    a_len_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_end_length != '0)) |-> (o_status == ST_DONE))
        else $error("end length outside done");

    // no stray char bits
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_out_char == '0))
        else $error("char bits set without char valid");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_char)
            && $stable(o_char_valid) && $stable(o_status) && $stable(o_end_length)))
        else $error("stalled output beat changed");

endmodule

bind quoted_string_literal_decoder qsld_chk u_qsld_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_char   (o_out_char),
    .o_char_valid (o_char_valid),
    .o_status     (o_status),
    .o_end_length (o_end_length)
);

/* tb/qsld_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsld_checker
// Watches both channels of the quoted string decoder, predicts one result
// per accepted input beat and compares every output beat field by field.
// ----------------------------------------------------------------------------
module qsld_checker
    import qsld_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_first,
    input  logic              i_in_last,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_out_char,
    input  logic              i_out_char_valid,
    input  logic [STAT_W-1:0] i_out_status,
    input  logic [LEN_W-1:0]  i_out_end_length,
    output int                o_fail_count,
    output int                o_pending
);

    t_mode       mode_q;
    logic [31:0] byte_count;
    t_res        decoded_beats[$];
    t_res        want;
    int          fail_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_cnt     = 0;
        mode_q       = M_IDLE;
        byte_count   = '0;
    end

    // decodes one byte and advances the parse state
    function automatic t_res decode_byte(input logic [BYTE_W-1:0] c, input logic f,
                                         input logic l);
        t_res              r;
        logic              raw;
        logic [BYTE_W-1:0] q;
        logic              taken;
        logic              closed;
        r      = '0;
        raw    = 1'b0;
        q      = CH_QUOTE;
        taken  = 1'b0;
        closed = 1'b0;
        if (f) begin
            byte_count = 32'd1;
            if ((c == CH_APOS || c == CH_QUOTE) && !l) begin
                mode_q   = (c == CH_APOS) ? M_RAW_OPEN : M_BASIC_OPEN;
                r.status = ST_BUSY;
            end else begin
                mode_q   = M_IDLE;
                r.status = ST_NOTSTR;
            end
        end else if (mode_q == M_IDLE) begin
            r.status = ST_IDLE;
        end else if (mode_q == M_RAW_EMPTY || mode_q == M_BASIC_EMPTY) begin
            // third byte after an empty string, looked at but not consumed
            q = (mode_q == M_RAW_EMPTY) ? CH_APOS : CH_QUOTE;
            if (c == q) begin
                r.status = ST_MULTI;
            end else begin
                r.status = ST_DONE;
                r.len    = LEN_W'(2);
            end
            mode_q = M_IDLE;
        end else begin
            raw = (mode_q == M_RAW_OPEN || mode_q == M_RAW_BODY);
            q   = raw ? CH_APOS : CH_QUOTE;
            if (byte_count != 32'hFFFF_FFFF)
                byte_count = byte_count + 32'd1;
            if (mode_q == M_RAW_OPEN || mode_q == M_BASIC_OPEN) begin
                if (c == q) begin
                    closed = 1'b1;
                    if (l) begin
                        r.status = ST_DONE;
                        r.len    = LEN_W'(2);
                        mode_q   = M_IDLE;
                    end else begin
                        r.status = ST_BUSY;
                        mode_q   = raw ? M_RAW_EMPTY : M_BASIC_EMPTY;
                    end
                end else begin
                    mode_q = raw ? M_RAW_BODY : M_BASIC_BODY;
                end
            end
            if (!closed) begin
                if (mode_q == M_BASIC_ESC) begin
                    taken = 1'b1;
                    case (c)
                        CH_LC_B:  r.ch = CH_BS;
                        CH_LC_T:  r.ch = CH_TAB;
                        CH_LC_N:  r.ch = CH_LF;
                        CH_LC_F:  r.ch = CH_FF;
                        CH_LC_R:  r.ch = CH_CR;
                        CH_LC_E:  r.ch = CH_ESC;
                        CH_QUOTE: r.ch = CH_QUOTE;
                        CH_BSL:   r.ch = CH_BSL;
                        default:  taken = 1'b0;
                    endcase
                    if (taken) begin
                        r.ch_vld = 1'b1;
                        mode_q   = M_BASIC_BODY;
                    end else begin
                        r.status = ST_BADESC;
                        mode_q   = M_IDLE;
                    end
                end else if (c == q) begin
                    r.status = ST_DONE;
                    r.len    = byte_count[LEN_W-1:0];
                    mode_q   = M_IDLE;
                end else if (!raw && c == CH_BSL) begin
                    taken  = 1'b1;
                    mode_q = M_BASIC_ESC;
                end else if (c == CH_TAB || (c >= CH_SPACE && c < CH_DEL)) begin
                    r.ch     = c;
                    r.ch_vld = 1'b1;
                    taken    = 1'b1;
                end else begin
                    r.status = (c < 8'd128) ? ST_CTRL : ST_NONASCII;
                    mode_q   = M_IDLE;
                end
                if (taken) begin
                    if (l || byte_count >= MAX_LEN) begin
                        r.status = ST_UNTERM;
                        r.ch     = '0;
                        r.ch_vld = 1'b0;
                        mode_q   = M_IDLE;
                    end else begin
                        r.status = ST_BUSY;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic flag(input string what, input logic [LEN_W-1:0] exp_v,
                        input logic [LEN_W-1:0] act_v);
        fail_cnt++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q     = M_IDLE;
            byte_count = '0;
            decoded_beats.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                decoded_beats.insert(decoded_beats.size(),
                                     decode_byte(i_in_byte, i_in_first, i_in_last));
            if (i_out_valid && !i_out_stall) begin
                if (decoded_beats.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: output beat with nothing pending, status %0h",
                             $time, i_out_status);
                end else begin
                    want = decoded_beats.pop_front();
                    if (i_out_char !== want.ch)
                        flag("out_char", LEN_W'(want.ch), LEN_W'(i_out_char));
                    if (i_out_char_valid !== want.ch_vld)
                        flag("char_valid", LEN_W'(want.ch_vld), LEN_W'(i_out_char_valid));
                    if (i_out_status !== want.status)
                        flag("status", LEN_W'(want.status), LEN_W'(i_out_status));
                    if (i_out_end_length !== want.len)
                        flag("end_length", want.len, i_out_end_length);
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= decoded_beats.size();
    end

endmodule

/* tb/quoted_string_literal_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_literal_decoder_tb
// Drives byte streams of raw and basic quoted strings into the decoder under
// random sender gaps and receiver stalls; a checker beside the block predicts
// and compares every result beat, and this top gives the verdict.
// ----------------------------------------------------------------------------
module quoted_string_literal_decoder_tb
    import qsld_pkg::*;
();

    localparam int MAX_LEN         = MAX_LEN_DEF;
    localparam int LIMIT_NS        = 1_000_000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int BEATS_PER_PHASE = 235;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic [BYTE_W-1:0] i_in_byte = '0;
    logic              i_first   = 1'b0;
    logic              i_last    = 1'b0;
    logic              i_stall   = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [BYTE_W-1:0] o_out_char;
    logic              o_char_valid;
    logic [STAT_W-1:0] o_status;
    logic [LEN_W-1:0]  o_end_length;

    // idle odds in percent, per cycle, for each side
    int send_pct  = 11;
    int recv_pct  = 48;
    // one long receiver hold-off, picked up by the receiver process
    bit hold_req  = 1'b0;
    int beats_sent = 0;
    int fail_count;
    int pending;

    quoted_string_literal_decoder #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_status     (o_status),
        .o_end_length (o_end_length)
    );

    qsld_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_in_byte),
        .i_in_first       (i_first),
        .i_in_last        (i_last),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_char       (o_out_char),
        .i_out_char_valid (o_char_valid),
        .i_out_status     (o_status),
        .i_out_end_length (o_end_length),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, or one long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_pct);
            end
        end
    end

    // offer one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input logic [BYTE_W-1:0] c, input logic f, input logic l);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= c;
        i_first   <= f;
        i_last    <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // a byte that a string body takes as it is
    function automatic logic [BYTE_W-1:0] body_byte(input logic raw);
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 9) == 0)
            return CH_TAB;
        c = BYTE_W'($urandom_range(32, 126));
        while (c == (raw ? CH_APOS : CH_QUOTE) || (!raw && c == CH_BSL))
            c = BYTE_W'($urandom_range(32, 126));
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] esc_letter(input int idx);
        case (idx)
            0:       return CH_LC_B;
            1:       return CH_LC_T;
            2:       return CH_LC_N;
            3:       return CH_LC_F;
            4:       return CH_LC_R;
            5:       return CH_LC_E;
            6:       return CH_QUOTE;
            default: return CH_BSL;
        endcase
    endfunction

    // one string: mostly well formed with random content, some broken or noise
    task automatic random_string();
        logic              raw;
        logic [BYTE_W-1:0] q;
        int                roll;
        int                len;
        logic              broken;
        logic              l;
        raw    = 1'($urandom_range(0, 1));
        q      = raw ? CH_APOS : CH_QUOTE;
        roll   = $urandom_range(0, 99);
        len    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
        broken = (roll >= 75);
        // noise opener, usually not a quote at all
        if (roll < 8) begin
            send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
            return;
        end
        // opener, a lone quote now and then when broken
        send_beat(q, 1'b1, broken && ($urandom_range(0, 9) == 0));
        for (int i = 0; i < len; i++) begin
            if (broken && $urandom_range(0, 19) == 0) begin
                // any byte, maybe restarting or ending the text
                send_beat(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0);
            end else if (!raw && $urandom_range(0, 3) == 0) begin
                send_beat(CH_BSL, 1'b0, 1'b0);
                if (broken && $urandom_range(0, 4) == 0)
                    send_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
                else
                    send_beat(esc_letter($urandom_range(0, 7)), 1'b0,
                              broken && $urandom_range(0, 9) == 0);
            end else begin
                send_beat(body_byte(raw), 1'b0, broken && $urandom_range(0, 29) == 0);
            end
        end
        // closing quote
        l = 1'($urandom_range(0, 1));
        send_beat(q, 1'b0, l);
        // empty string: the third byte may open a multi-line string
        if (len == 0 && !l && $urandom_range(0, 2) == 0)
            send_beat(q, 1'b0, 1'($urandom_range(0, 1)));
        // trailing byte: decides an empty string, otherwise ignored while idle
        if ($urandom_range(0, 9) < 3)
            send_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stray byte while idle, ignored
        send_beat(8'h00, 1'b0, 1'b0);
        // not a quote first, top byte value
        send_beat(8'hFF, 1'b1, 1'b1);
        // lone quote at the end of the text
        send_beat(CH_QUOTE, 1'b1, 1'b1);
        // empty raw string closing on the last byte
        send_beat(CH_APOS, 1'b1, 1'b0);
        send_beat(CH_APOS, 1'b0, 1'b1);
        // three double quotes: multi-line opener
        send_beat(CH_QUOTE, 1'b1, 1'b0);
        send_beat(CH_QUOTE, 1'b0, 1'b0);
        send_beat(CH_QUOTE, 1'b0, 1'b0);
        // empty raw string decided by a third byte that is not consumed
        send_beat(CH_APOS, 1'b1, 1'b0);
        send_beat(CH_APOS, 1'b0, 1'b0);
        send_beat(8'h7A, 1'b0, 1'b0);
        // bad escape, hex form
        send_beat(CH_QUOTE, 1'b1, 1'b0);
        send_beat(CH_BSL, 1'b0, 1'b0);
        send_beat(8'h78, 1'b0, 1'b0);
        // control byte in a raw string
        send_beat(CH_APOS, 1'b1, 1'b0);
        send_beat(8'h1F, 1'b0, 1'b0);
        // non-ascii byte in a basic string
        send_beat(CH_QUOTE, 1'b1, 1'b0);
        send_beat(8'h80, 1'b0, 1'b0);
        // trailing backslash runs out of text
        send_beat(CH_QUOTE, 1'b1, 1'b0);
        send_beat(CH_BSL, 1'b0, 1'b1);
        // backslash is plain inside a raw string
        send_beat(CH_APOS, 1'b1, 1'b0);
        send_beat(CH_BSL, 1'b0, 1'b0);
        send_beat(CH_APOS, 1'b0, 1'b1);

        // three idling phases: slow receiver, slow sender, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_pct = 11;
                    recv_pct = 48;
                end
                1: begin
                    send_pct = 48;
                    recv_pct = 11;
                end
                default: begin
                    send_pct = 0;
                    recv_pct = 0;
                    // long hold-off so the block fills and stalls its input
                    hold_req = 1'b1;
                end
            endcase
            target = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < target)
                random_string();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/qsld_pkg.sv
rtl/qsld_step.sv
rtl/quoted_string_literal_decoder.sv
rtl/qsld_chk.sv
tb/qsld_checker.sv
tb/quoted_string_literal_decoder_tb.sv
